### rtl/todcc_pkg.sv
package todcc_pkg;

    // Field widths of the input and result items.
    localparam int ModeWidth    = 4;
    localparam int ValueWidth   = 7;
    localparam int MsWidth      = 10;
    localparam int SecWidth     = 6;
    localparam int MinWidth     = 6;
    localparam int HourWidth    = 5;
    localparam int DayWidth     = 5;
    localparam int MonthWidth   = 4;
    localparam int YearWidth    = 7;

    // Packed stream widths, rounded up to whole bytes.
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 48;

    // Top values of each counter.
    localparam logic [MsWidth-1:0]    MsMax    = 10'd999;
    localparam logic [SecWidth-1:0]   SecMax   = 6'd59;
    localparam logic [MinWidth-1:0]   MinMax   = 6'd59;
    localparam logic [HourWidth-1:0]  HourMax  = 5'd23;
    localparam logic [DayWidth-1:0]   DayMax   = 5'd31;
    localparam logic [MonthWidth-1:0] MonthMax = 4'd12;
    localparam logic [YearWidth-1:0]  YearMax  = 7'd99;

    // State after reset.
    localparam logic [MsWidth-1:0]    MsReset    = 10'd0;
    localparam logic [SecWidth-1:0]   SecReset   = 6'd0;
    localparam logic [MinWidth-1:0]   MinReset   = 6'd6;
    localparam logic [HourWidth-1:0]  HourReset  = 5'd11;
    localparam logic [DayWidth-1:0]   DayReset   = 5'd1;
    localparam logic [MonthWidth-1:0] MonthReset = 4'd1;
    localparam logic [YearWidth-1:0]  YearReset  = 7'd14;
    localparam logic [MsWidth-1:0]    StepReset  = 10'd1;

    // Item kinds carried in the input tuser.
    typedef enum logic [ModeWidth-1:0] {
        MODE_TICK      = 4'd0,
        MODE_SET_HOUR  = 4'd1,
        MODE_SET_MIN   = 4'd2,
        MODE_SET_SEC   = 4'd3,
        MODE_SET_DAY   = 4'd4,
        MODE_SET_MONTH = 4'd5,
        MODE_SET_YEAR  = 4'd6,
        MODE_INC_HOUR  = 4'd7,
        MODE_INC_MIN   = 4'd8,
        MODE_INC_SEC   = 4'd9,
        MODE_DEC_HOUR  = 4'd10,
        MODE_DEC_MIN   = 4'd11,
        MODE_DEC_SEC   = 4'd12
    } mode_t;

    // Days in a month; February always has 28.
    function automatic logic [DayWidth-1:0] month_length(input logic [MonthWidth-1:0] mon);
        logic [DayWidth-1:0] len;
        case (mon)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/time_of_day_calendar_counter.sv
// Real-time clock and calendar with a two-digit year. Every input item is
// answered by exactly one result item that carries the whole time and date
// after the update, and an item is taken in every cycle in which the result
// side is free or is being read: the update is a single short pass of
// compare-and-increment logic from the counters back into the counters, so
// the result is ready in the next cycle, at one item per cycle. A tick
// item adds ms_per_tick milliseconds; a count above 999 clears to zero and
// carries one second, and the carry ripples on to the year, which wraps
// after 99. February has 28 days and leap years are not handled. Other items
// set one field, clamped to its range, or step hours, minutes or seconds up
// or down with wrap. Write ms_per_tick only while no item is in flight.
module time_of_day_calendar_counter
    import todcc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [MsWidth-1:0]      cfg_wdata,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [6:0] value, [7] zero
    input  logic [InDataWidth-1:0]  s_axis_tdata,
    // [3:0] mode
    input  logic [ModeWidth-1:0]    s_axis_tuser,

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [9:0] milliseconds, [15:10] seconds_now, [21:16] minutes_now,
    // [26:22] hours_now, [31:27] day_now, [35:32] month_now,
    // [42:36] year_now, [47:43] zero
    output logic [OutDataWidth-1:0] m_axis_tdata
);

    logic [MsWidth-1:0]    step_reg;
    logic [MsWidth-1:0]    ms_reg,    ms_next;
    logic [SecWidth-1:0]   sec_reg,   sec_next;
    logic [MinWidth-1:0]   min_reg,   min_next;
    logic [HourWidth-1:0]  hour_reg,  hour_next;
    logic [DayWidth-1:0]   day_reg,   day_next;
    logic [MonthWidth-1:0] month_reg, month_next;
    logic [YearWidth-1:0]  year_reg,  year_next;
    logic                  valid_reg;

    logic                  accept;
    logic [ValueWidth-1:0] value;

    // Tick carry chain.
    logic [MsWidth:0]      ms_sum;
    logic                  carry_sec;
    logic                  carry_min;
    logic                  carry_hour;
    logic                  carry_day;
    logic                  carry_month;
    logic                  carry_year;
    logic [SecWidth-1:0]   sec_inc;
    logic [MinWidth-1:0]   min_inc;
    logic [HourWidth-1:0]  hour_inc;
    logic [DayWidth:0]     day_inc;
    logic [MonthWidth-1:0] month_inc;
    logic [YearWidth-1:0]  year_inc;
    logic [MsWidth-1:0]    ms_tick;
    logic [SecWidth-1:0]   sec_tick;
    logic [MinWidth-1:0]   min_tick;
    logic [HourWidth-1:0]  hour_tick;
    logic [DayWidth-1:0]   day_tick;
    logic [MonthWidth-1:0] month_tick;
    logic [YearWidth-1:0]  year_tick;

    // The counters hold the result, so an item is taken only when the
    // result register is empty or being read in the same cycle.
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign value         = s_axis_tdata[ValueWidth-1:0];

    // Millisecond step and the ripple of carries up to the year.
    always_comb
    begin
        ms_sum      = {1'b0, ms_reg} + {1'b0, step_reg};
        carry_sec   = ms_sum > {1'b0, MsMax};
        ms_tick     = carry_sec ? '0 : ms_sum[MsWidth-1:0];

        sec_inc     = sec_reg + {{(SecWidth-1){1'b0}}, carry_sec};
        carry_min   = sec_inc > SecMax;
        sec_tick    = carry_min ? '0 : sec_inc;

        min_inc     = min_reg + {{(MinWidth-1){1'b0}}, carry_min};
        carry_hour  = min_inc > MinMax;
        min_tick    = carry_hour ? '0 : min_inc;

        hour_inc    = hour_reg + {{(HourWidth-1){1'b0}}, carry_hour};
        carry_day   = hour_inc > HourMax;
        hour_tick   = carry_day ? '0 : hour_inc;

        // A day set beyond the month length also rolls the month over here.
        day_inc     = {1'b0, day_reg} + {{DayWidth{1'b0}}, carry_day};
        carry_month = day_inc > {1'b0, month_length(month_reg)};
        day_tick    = carry_month ? 5'd1 : day_inc[DayWidth-1:0];

        month_inc   = month_reg + {{(MonthWidth-1){1'b0}}, carry_month};
        carry_year  = month_inc > MonthMax;
        month_tick  = carry_year ? 4'd1 : month_inc;

        year_inc    = year_reg + {{(YearWidth-1){1'b0}}, carry_year};
        year_tick   = (year_inc > YearMax) ? '0 : year_inc;
    end

    // Next state for each kind of item.
    always_comb
    begin
        ms_next    = ms_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        unique case (mode_t'(s_axis_tuser))
            MODE_TICK:
            begin
                ms_next    = ms_tick;
                sec_next   = sec_tick;
                min_next   = min_tick;
                hour_next  = hour_tick;
                day_next   = day_tick;
                month_next = month_tick;
                year_next  = year_tick;
            end
            MODE_SET_HOUR:
                hour_next = (value > {2'b0, HourMax}) ? HourMax : value[HourWidth-1:0];
            MODE_SET_MIN:
                min_next = (value > {1'b0, MinMax}) ? MinMax : value[MinWidth-1:0];
            MODE_SET_SEC:
                sec_next = (value > {1'b0, SecMax}) ? SecMax : value[SecWidth-1:0];
            MODE_SET_DAY:
            begin
                if (value == '0)
                    day_next = 5'd1;
                else if (value > {2'b0, DayMax})
                    day_next = DayMax;
                else
                    day_next = value[DayWidth-1:0];
            end
            MODE_SET_MONTH:
            begin
                if (value == '0)
                    month_next = 4'd1;
                else if (value > {3'b0, MonthMax})
                    month_next = MonthMax;
                else
                    month_next = value[MonthWidth-1:0];
            end
            MODE_SET_YEAR:
                year_next = (value > YearMax) ? YearMax : value;
            MODE_INC_HOUR:
                hour_next = (hour_reg >= HourMax) ? '0 : hour_reg + 5'd1;
            MODE_INC_MIN:
                min_next = (min_reg >= MinMax) ? '0 : min_reg + 6'd1;
            MODE_INC_SEC:
                sec_next = (sec_reg >= SecMax) ? '0 : sec_reg + 6'd1;
            MODE_DEC_HOUR:
                hour_next = (hour_reg == '0) ? HourMax : hour_reg - 5'd1;
            MODE_DEC_MIN:
                min_next = (min_reg == '0) ? MinMax : min_reg - 6'd1;
            MODE_DEC_SEC:
                sec_next = (sec_reg == '0) ? SecMax : sec_reg - 6'd1;
            default:
            begin
                // Unused kinds leave the time and date alone.
            end
        endcase
    end

    // Counters, step register and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= StepReset;
            ms_reg    <= MsReset;
            sec_reg   <= SecReset;
            min_reg   <= MinReset;
            hour_reg  <= HourReset;
            day_reg   <= DayReset;
            month_reg <= MonthReset;
            year_reg  <= YearReset;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                step_reg <= cfg_wdata;
            if (accept)
            begin
                ms_reg    <= ms_next;
                sec_reg   <= sec_next;
                min_reg   <= min_next;
                hour_reg  <= hour_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
            end
            if (accept)
                valid_reg <= 1'b1;
            else if (m_axis_tready)
                valid_reg <= 1'b0;
        end
    end

    // Result item straight from the counters.
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'b0, year_reg, month_reg, day_reg, hour_reg,
                            min_reg, sec_reg, ms_reg};

`ifndef SYNTHESIS
    // Every accepted item leaves a result waiting.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("accepted item produced no result");

    // Without an accepted item the time and date do not move.
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(ms_reg) && $stable(sec_reg) && $stable(min_reg)
                     && $stable(hour_reg) && $stable(day_reg)
                     && $stable(month_reg) && $stable(year_reg)))
        else $error("time changed without an item");

    // A tick that does not overflow the milliseconds leaves the seconds.
    a_no_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == MODE_TICK && !carry_sec) |=> $stable(sec_reg))
        else $error("seconds moved without a millisecond carry");

    // Setting the hour within range stores the value as given.
    a_set_hour: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == MODE_SET_HOUR && value <= 7'd23)
        |=> hour_reg == $past(value[HourWidth-1:0]))
        else $error("hour not set to the requested value");

    // The calendar stays within its ranges.
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (ms_reg <= MsMax && sec_reg <= SecMax && min_reg <= MinMax
                       && hour_reg <= HourMax && day_reg != '0
                       && month_reg != '0 && month_reg <= MonthMax
                       && year_reg <= YearMax))
        else $error("time or date out of range");
`endif

endmodule

### tb/tb.sv
module tb;
    import todcc_pkg::*;

    // Run limits and sizes.
    localparam int CycleLimit   = 800000;
    localparam int RandomItems  = 1060;
    localparam int PhaseItems   = 110;
    localparam int LongHold     = 300;
    localparam int ReportLimit  = 10;
    localparam int SettleCycles = 10;

    localparam logic [ValueWidth-1:0] ValueTop      = '1;
    localparam logic [ModeWidth-1:0]  FirstSpareMode = MODE_DEC_SEC + 1'b1;
    localparam logic [ModeWidth-1:0]  LastSpareMode  = '1;
    localparam logic [MsWidth-1:0]    StepTop        = '1;

    // One time and date, laid out exactly as the result tdata carries it.
    typedef struct packed {
        logic [YearWidth-1:0]  year;
        logic [MonthWidth-1:0] month;
        logic [DayWidth-1:0]   day;
        logic [HourWidth-1:0]  hour;
        logic [MinWidth-1:0]   minute;
        logic [SecWidth-1:0]   sec;
        logic [MsWidth-1:0]    ms;
    } calendar_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [MsWidth-1:0]      cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // [6:0] value, [7] zero
    logic [InDataWidth-1:0]  s_axis_tdata;
    // [3:0] mode
    logic [ModeWidth-1:0]    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [9:0] milliseconds, [15:10] seconds_now, [21:16] minutes_now,
    // [26:22] hours_now, [31:27] day_now, [35:32] month_now,
    // [42:36] year_now, [47:43] zero
    logic [OutDataWidth-1:0] m_axis_tdata;

    // Expected clock readings, oldest first, and the predicted clock itself.
    calendar_t          expected_times[$];
    calendar_t          clock_now = '{year: YearReset, month: MonthReset, day: DayReset,
                                      hour: HourReset, minute: MinReset, sec: SecReset,
                                      ms: MsReset};
    logic [MsWidth-1:0] tick_step = StepReset;

    int items_taken;
    int results_seen;
    int ticks_taken;
    int step_writes;
    int failures;
    int cycle_count;
    int tx_gap_pct;
    int rx_stall_pct;
    int long_hold_len;

    int unsigned boundary_values[] = '{0, 1, 2, 11, 12, 13, 22, 23, 24, 27, 28, 29, 30,
                                       31, 32, 58, 59, 60, 98, 99, 100, 126, 127};

    time_of_day_calendar_counter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Length of the month, with no leap years.
    function automatic int days_in_month(int month);
        if (month == 2)
            return 28;
        if (month inside {4, 6, 9, 11})
            return 30;
        return 31;
    endfunction

    function automatic int clamp_to(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Work out the clock after one item, carries and clamps included.
    function automatic calendar_t advance_calendar(calendar_t now,
                                                   logic [ModeWidth-1:0] mode,
                                                   logic [ValueWidth-1:0] value,
                                                   logic [MsWidth-1:0] step);
        int        ms;
        int        sec;
        int        minute;
        int        hour;
        int        day;
        int        month;
        int        year;
        calendar_t next;
        ms     = now.ms;
        sec    = now.sec;
        minute = now.minute;
        hour   = now.hour;
        day    = now.day;
        month  = now.month;
        year   = now.year;
        case (mode)
            MODE_TICK:
            begin
                // Any sum past the top clears the count and carries one second.
                ms = ms + int'(step);
                if (ms > MsMax)
                begin
                    sec++;
                    ms = 0;
                end
                if (sec > SecMax)
                begin
                    minute++;
                    sec = 0;
                end
                if (minute > MinMax)
                begin
                    hour++;
                    minute = 0;
                end
                if (hour > HourMax)
                begin
                    day++;
                    hour = 0;
                end
                // A day set beyond the month length also moves the month on.
                if (day > days_in_month(month))
                begin
                    month++;
                    day = 1;
                end
                if (month > MonthMax)
                begin
                    year++;
                    month = 1;
                end
                if (year > YearMax)
                    year = 0;
            end
            MODE_SET_HOUR:  hour   = clamp_to(value, 0, HourMax);
            MODE_SET_MIN:   minute = clamp_to(value, 0, MinMax);
            MODE_SET_SEC:   sec    = clamp_to(value, 0, SecMax);
            MODE_SET_DAY:   day    = clamp_to(value, 1, DayMax);
            MODE_SET_MONTH: month  = clamp_to(value, 1, MonthMax);
            MODE_SET_YEAR:  year   = clamp_to(value, 0, YearMax);
            MODE_INC_HOUR:  hour   = (hour >= HourMax) ? 0 : hour + 1;
            MODE_INC_MIN:   minute = (minute >= MinMax) ? 0 : minute + 1;
            MODE_INC_SEC:   sec    = (sec >= SecMax) ? 0 : sec + 1;
            MODE_DEC_HOUR:  hour   = (hour == 0) ? HourMax : hour - 1;
            MODE_DEC_MIN:   minute = (minute == 0) ? MinMax : minute - 1;
            MODE_DEC_SEC:   sec    = (sec == 0) ? SecMax : sec - 1;
            default:        ;
        endcase
        next.ms     = ms[MsWidth-1:0];
        next.sec    = sec[SecWidth-1:0];
        next.minute = minute[MinWidth-1:0];
        next.hour   = hour[HourWidth-1:0];
        next.day    = day[DayWidth-1:0];
        next.month  = month[MonthWidth-1:0];
        next.year   = year[YearWidth-1:0];
        return next;
    endfunction

    function automatic string show_time(calendar_t t);
        return $sformatf("%02d:%02d:%02d.%03d %02d/%02d/%02d",
                         t.hour, t.minute, t.sec, t.ms, t.day, t.month, t.year);
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= ReportLimit)
            $display("ERROR: %s", msg);
    endfunction

    // Gaps are mostly short, now and then long.
    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Follow register writes and accepted items, and queue the clock they should give.
    always @(posedge clk)
    begin
        if (cfg_we)
        begin
            tick_step = cfg_wdata;
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            clock_now = advance_calendar(clock_now, s_axis_tuser,
                                         s_axis_tdata[ValueWidth-1:0], tick_step);
            expected_times.push_back(clock_now);
            items_taken++;
            if (s_axis_tuser == MODE_TICK)
                ticks_taken++;
        end
    end

    // Compare each result item with the oldest expected reading.
    always @(posedge clk)
    begin : check_result
        calendar_t got;
        calendar_t want;
        string     diff;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(calendar_t)-1:0];
            results_seen++;
            if (expected_times.size() == 0)
            begin
                note_failure($sformatf("result %0d (%s) arrived with nothing expected",
                                       results_seen, show_time(got)));
            end
            else
            begin
                want = expected_times.pop_front();
                diff = "";
                if (got.ms !== want.ms)         diff = {diff, " milliseconds"};
                if (got.sec !== want.sec)       diff = {diff, " seconds"};
                if (got.minute !== want.minute) diff = {diff, " minutes"};
                if (got.hour !== want.hour)     diff = {diff, " hours"};
                if (got.day !== want.day)       diff = {diff, " day"};
                if (got.month !== want.month)   diff = {diff, " month"};
                if (got.year !== want.year)     diff = {diff, " year"};
                if (diff != "")
                    note_failure($sformatf("result %0d wrong in%s: expected %s, got %s",
                                           results_seen, diff, show_time(want),
                                           show_time(got)));
            end
        end
    end

    // Result side: random stalls, plus a long hold when a test asks for one.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (long_hold_len != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (long_hold_len) @(posedge clk);
                long_hold_len = 0;
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(99) < rx_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap_length()) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    task automatic idle_input(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Offer one item and hold it until it is taken; valid stays high for a
    // following item unless a gap is drawn.
    task automatic send_item(input logic [ModeWidth-1:0] mode,
                             input logic [ValueWidth-1:0] value);
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(InDataWidth - ValueWidth){1'b0}}, value};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if ($urandom_range(99) < tx_gap_pct)
            idle_input(gap_length());
    endtask

    // Stop offering items until every expected result has come back. The task
    // waits on a clock edge first so that the last accepted item is already in the queue.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // The step register is only written with nothing in flight.
    task automatic write_tick_step(input logic [MsWidth-1:0] step);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= step;
        @(posedge clk);
        cfg_we    <= 1'b0;
        step_writes++;
    endtask

    // Every set clamps at the top, day and month also at zero; leaves the clock at 23:59:59.001 on 31/12/99.
    task automatic test_field_limits();
        send_item(MODE_TICK, ValueTop);
        send_item(MODE_SET_HOUR, '0);
        send_item(MODE_SET_HOUR, ValueTop);
        send_item(MODE_SET_MIN, ValueTop);
        send_item(MODE_SET_SEC, ValueTop);
        send_item(MODE_SET_DAY, '0);
        send_item(MODE_SET_DAY, ValueTop);
        send_item(MODE_SET_MONTH, '0);
        send_item(MODE_SET_MONTH, ValueTop);
        send_item(MODE_SET_YEAR, ValueTop);
    endtask

    // One tick of a full second ripples through every field and wraps the year.
    task automatic test_full_rollover();
        write_tick_step(10'd1000);
        send_item(MODE_TICK, '0);
    endtask

    // With no step at all, a day beyond the month length still moves the month on.
    task automatic test_short_month();
        write_tick_step('0);
        send_item(MODE_SET_MONTH, 7'd2);
        send_item(MODE_SET_DAY, 7'd29);
        send_item(MODE_TICK, ValueTop);
        send_item(MODE_SET_MONTH, 7'd4);
        send_item(MODE_SET_DAY, 7'd31);
        send_item(MODE_TICK, '0);
    endtask

    // Increments and decrements wrap at both ends and ignore the value.
    task automatic test_step_wrap();
        send_item(MODE_SET_HOUR, 7'd23);
        send_item(MODE_INC_HOUR, ValueTop);
        send_item(MODE_DEC_HOUR, ValueTop);
        send_item(MODE_SET_MIN, '0);
        send_item(MODE_DEC_MIN, ValueTop);
        send_item(MODE_INC_MIN, '0);
        send_item(MODE_SET_SEC, 7'd59);
        send_item(MODE_INC_SEC, ValueTop);
        send_item(MODE_DEC_SEC, '0);
    endtask

    // Unused modes leave the clock alone; then the largest step the register holds.
    task automatic test_spare_modes_and_top_step();
        for (int m = FirstSpareMode; m <= LastSpareMode; m++)
            send_item(m[ModeWidth-1:0], ValueTop);
        write_tick_step(StepTop);
        send_item(MODE_TICK, ValueTop);
    endtask

    // One random item, weighted towards ticks and sets near the field limits.
    task automatic send_random_item(output bit counted);
        int                    r;
        logic [ModeWidth-1:0]  mode;
        logic [ValueWidth-1:0] value;
        r       = $urandom_range(99);
        value   = ValueWidth'($urandom_range(0, ValueTop));
        counted = 1'b1;
        if (r < 40)
        begin
            mode = MODE_TICK;
        end
        else if (r < 70)
        begin
            mode = ModeWidth'($urandom_range(MODE_SET_HOUR, MODE_SET_YEAR));
            if ($urandom_range(1) == 0)
                value = ValueWidth'(boundary_values[$urandom_range(boundary_values.size() - 1)]);
        end
        else if (r < 95)
        begin
            mode = ModeWidth'($urandom_range(MODE_INC_HOUR, MODE_DEC_SEC));
        end
        else
        begin
            mode    = ModeWidth'($urandom_range(FirstSpareMode, LastSpareMode));
            counted = 1'b0;
        end
        send_item(mode, value);
    endtask

    // Phases of random traffic, each with its own step and its own idling.
    task automatic test_random_traffic();
        logic [MsWidth-1:0] preset_steps[] = '{StepTop, 10'd0, 10'd1000, 10'd999, 10'd1,
                                               10'd500};
        logic [MsWidth-1:0] step;
        int                 counted;
        int                 phase;
        bit                 hit;
        counted = 0;
        phase   = 0;
        while (counted < RandomItems)
        begin
            if (phase < preset_steps.size())
                step = preset_steps[phase];
            else if ($urandom_range(1) == 0)
                step = MsWidth'($urandom_range(400, StepTop));
            else
                step = MsWidth'($urandom_range(0, StepTop));
            write_tick_step(step);
            tx_gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            rx_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            for (int i = 0; i < PhaseItems && counted < RandomItems; i++)
            begin
                send_random_item(hit);
                if (hit)
                    counted++;
            end
            phase++;
        end
    endtask

    // The receiver holds off while items keep coming, so the input stalls;
    // afterwards the sender waits for every result before going on.
    task automatic test_output_backpressure();
        bit hit;
        write_tick_step(10'd700);
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        long_hold_len = LongHold;
        repeat (40) send_random_item(hit);
        wait_for_results();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        repeat (20) send_random_item(hit);
        wait_for_results();
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_TICK;
        tx_gap_pct    = 20;
        rx_stall_pct  = 20;
        long_hold_len = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_limits();
        test_full_rollover();
        test_short_month();
        test_step_wrap();
        test_spare_modes_and_top_step();
        test_output_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (SettleCycles) @(posedge clk);
        $display("Sent %0d items (%0d ticks) over %0d step settings, checked %0d results.",
                 items_taken, ticks_taken, step_writes, results_seen);
        $display("Covered clamps, wraps, full calendar rollover and output stalls; %0d failures.",
                 failures);
        if (failures == 0 && expected_times.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
